// ----- src/bdhr_pkg.sv -----
// Shared types, constants and register indexes for the button debouncer.
`timescale 1ns / 1ps
package bdhr_pkg;

  localparam int NumButtonsDef = 8;
  localparam int FifoDepthDef  = 4;

  localparam int BtnW  = 3;
  localparam int TickW = 10;
  localparam int KindW = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 10;

  localparam logic [KindW-1:0] KIND_RELEASED = 2'd0;
  localparam logic [KindW-1:0] KIND_PRESS    = 2'd1;
  localparam logic [KindW-1:0] KIND_HOLD     = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_HOLD_TICKS   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_REPEAT_TICKS = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LEVEL = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GLOBAL_EN    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BUTTON_MASK  = 3'd4;

  typedef struct packed {
    logic [2:0]       hist;
    logic             stab;
    logic [TickW-1:0] cd;
    logic [KindW-1:0] cur;
    logic [KindW-1:0] rep;
    logic [TickW-1:0] rcnt;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    hist: 3'b111, stab: 1'b1, cd: '0, cur: KIND_RELEASED, rep: KIND_RELEASED, rcnt: '0
  };

  typedef struct packed {
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] repeat_ticks;
    logic             active_level;
  } cfg_t;

  typedef struct packed {
    entry_t           entry;
    logic             emit;
    logic [KindW-1:0] kind;
  } upd_t;

endpackage

// ----- src/bdhr_state_ram.sv -----
// Per-button state memory, one write port and one registered read port.
`timescale 1ns / 1ps
module bdhr_state_ram #(
  parameter int Depth = 8,
  parameter int AddrW = 3,
  parameter int DataW = 28
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/bdhr_update.sv -----
// Debounce, hold countdown and repeat update of one button entry.
`timescale 1ns / 1ps
module bdhr_update
  import bdhr_pkg::*;
(
  input  cfg_t   cfg_i,
  input  logic   en_i,
  input  logic   pin_i,
  input  entry_t entry_i,
  output upd_t   upd_o
);

  logic [2:0]       h;
  logic [TickW-1:0] cd1;
  logic [KindW-1:0] cur1;
  logic [TickW-1:0] rc1;
  logic [TickW-1:0] rc2;
  logic             settle;

  always_comb begin
    h    = {entry_i.hist[1:0], pin_i};
    cd1  = entry_i.cd;
    cur1 = entry_i.cur;
    rc1  = entry_i.rcnt;
    rc2  = '0;
    upd_o = '{entry: entry_i, emit: 1'b0, kind: KIND_RELEASED};
    upd_o.entry.hist = h;

    if (entry_i.cd != '0) begin
      cd1 = entry_i.cd - 1'b1;
      if (cd1 == '0) begin
        cur1 = KIND_HOLD;
        rc1  = '0;
      end
    end

    settle = ((h == 3'b000) || (h == 3'b111)) && (h[0] != entry_i.stab);
    upd_o.entry.cd   = cd1;
    upd_o.entry.cur  = cur1;
    upd_o.entry.rcnt = rc1;
    if (settle) begin
      upd_o.entry.stab = h[0];
      if (h[0] == cfg_i.active_level) begin
        upd_o.entry.cd = cfg_i.hold_ticks;
      end else begin
        upd_o.entry.cur = (cd1 != '0) ? KIND_PRESS : KIND_RELEASED;
        upd_o.entry.cd  = '0;
      end
    end

    if (upd_o.entry.cur != entry_i.rep) begin
      if (en_i) begin
        upd_o.emit = 1'b1;
        upd_o.kind = upd_o.entry.cur;
        if (upd_o.entry.cur == KIND_PRESS) begin
          upd_o.entry.cur = KIND_RELEASED;
        end
        upd_o.entry.rep = upd_o.entry.cur;
      end
    end else if (upd_o.entry.cur == KIND_HOLD) begin
      rc2 = upd_o.entry.rcnt + 1'b1;
      upd_o.entry.rcnt = rc2;
      if (rc2 >= cfg_i.repeat_ticks) begin
        upd_o.entry.rcnt = '0;
        upd_o.entry.rep  = KIND_RELEASED;
        if (en_i) begin
          upd_o.entry.rep = KIND_HOLD;
          upd_o.emit = 1'b1;
          upd_o.kind = KIND_HOLD;
        end
      end
    end
  end

endmodule

// ----- src/bdhr_out_fifo.sv -----
// Event output queue that decouples the update pipeline from the sink.
`timescale 1ns / 1ps
module bdhr_out_fifo
  import bdhr_pkg::*;
#(
  parameter int Depth = FifoDepthDef,
  parameter int DataW = BtnW + KindW
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  logic [DataW-1:0]         data_i,
  input  logic                     pop_i,
  output logic                     valid_o,
  output logic [DataW-1:0]         data_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [DataW-1:0] slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rd_ptr_q];
  assign count_o = cnt_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CntW'(Depth)) |-> (!push_i || do_pop))
    else $error("event queue overflow");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("event queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("event queue pointers disagree with empty count");

endmodule

// ----- src/button_debounce_hold_repeat.sv -----
// Top level: multi-button debouncer with long-press detection and hold repeat.
//
//  channel   dir   signals                        content
//  s_axis    in    s_axis_tvalid/tready/tdata     one tick sample of one button
//  m_axis    out   m_axis_tvalid/tready/tdata     one button event
//  cfg       in    cfg_we_i/cfg_idx_i/cfg_wdata_i register write, no read-back
//
//  One sample per cycle while the queue has room; the per-button state RAM
//  is read at acceptance and written in the cycle after, with the last write
//  forwarded to a following sample of the same button. Reset clears per-entry
//  valid bits; an unwritten entry reads as idle state. Events wait in a small
//  queue; input stalls only when the queue may fill.
`timescale 1ns / 1ps
module button_debounce_hold_repeat
  import bdhr_pkg::*;
#(
  parameter int NUM_BUTTONS = NumButtonsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [2:0] button_index, [3] pin_level
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [2:0] event_button, [4:3] event_kind
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  localparam int AddrW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int EntryW = $bits(entry_t);
  localparam int FifoDepth = FifoDepthDef;
  localparam int CntW = $clog2(FifoDepth + 1);

  logic [TickW-1:0] hold_ticks_q, repeat_ticks_q;
  logic             active_level_q, global_en_q;
  logic [7:0]       mask_q;

  logic [BtnW-1:0]  in_btn;
  logic             in_pin, in_range, accept, take;
  logic [AddrW-1:0] in_addr;

  logic             s1_vld_q;
  logic [BtnW-1:0]  s1_btn_q;
  logic             s1_pin_q;
  logic [AddrW-1:0] s1_addr;

  logic [NUM_BUTTONS-1:0] ent_vld_q;
  entry_t           wb_q;
  logic [AddrW-1:0] wb_addr_q;
  logic             wb_vld_q;

  logic [EntryW-1:0] rdata;
  entry_t           cur_entry;
  cfg_t             cfg;
  upd_t             upd;
  logic             en;
  logic             push;
  logic [CntW-1:0]  fifo_cnt;
  logic [BtnW+KindW-1:0] fifo_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ticks_q   <= 10'd50;
      repeat_ticks_q <= 10'd10;
      active_level_q <= 1'b0;
      global_en_q    <= 1'b1;
      mask_q         <= 8'hFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_HOLD_TICKS:   hold_ticks_q   <= cfg_wdata_i;
        REG_REPEAT_TICKS: repeat_ticks_q <= cfg_wdata_i;
        REG_ACTIVE_LEVEL: active_level_q <= cfg_wdata_i[0];
        REG_GLOBAL_EN:    global_en_q    <= cfg_wdata_i[0];
        REG_BUTTON_MASK:  mask_q         <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_btn   = s_axis_tdata[2:0];
  assign in_pin   = s_axis_tdata[3];
  assign in_range = 32'(in_btn) < NUM_BUTTONS;
  assign in_addr  = AddrW'(in_btn);
  assign s_axis_tready = (32'(fifo_cnt) + 32'(s1_vld_q)) < FifoDepth;
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign take     = accept && in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_btn_q <= in_btn;
      s1_pin_q <= in_pin;
    end
  end

  assign s1_addr = AddrW'(s1_btn_q);

  bdhr_state_ram #(
    .Depth (NUM_BUTTONS),
    .AddrW (AddrW),
    .DataW (EntryW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (s1_vld_q),
    .waddr_i (s1_addr),
    .wdata_i (upd.entry),
    .re_i    (take),
    .raddr_i (in_addr),
    .rdata_o (rdata)
  );

  always_comb begin
    if (wb_vld_q && (wb_addr_q == s1_addr)) begin
      cur_entry = wb_q;
    end else if (ent_vld_q[s1_addr]) begin
      cur_entry = entry_t'(rdata);
    end else begin
      cur_entry = ENTRY_RESET;
    end
  end

  assign cfg = '{hold_ticks: hold_ticks_q, repeat_ticks: repeat_ticks_q,
                 active_level: active_level_q};
  assign en  = global_en_q && mask_q[s1_btn_q];

  bdhr_update u_update (
    .cfg_i   (cfg),
    .en_i    (en),
    .pin_i   (s1_pin_q),
    .entry_i (cur_entry),
    .upd_o   (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      wb_vld_q  <= 1'b0;
    end else if (s1_vld_q) begin
      ent_vld_q[s1_addr] <= 1'b1;
      wb_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      wb_q      <= upd.entry;
      wb_addr_q <= s1_addr;
    end
  end

  assign push = s1_vld_q && upd.emit;

  bdhr_out_fifo #(
    .Depth (FifoDepth),
    .DataW (BtnW + KindW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({upd.kind, s1_btn_q}),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (fifo_out),
    .count_o (fifo_cnt)
  );

  assign m_axis_tdata = {3'b000, fifo_out};

  a_room_for_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |-> (32'(fifo_cnt) < FifoDepth))
    else $error("stage-1 item without queue room");

  a_written_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q |=> ent_vld_q[$past(s1_addr)])
    else $error("entry written but not marked valid");

  a_forward_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && take && (in_addr == s1_addr)) |=> (wb_vld_q && (wb_addr_q == s1_addr)))
    else $error("back-to-back sample of same button missed forwarding");

endmodule

// ----- tb/sv/tb_button_debounce_hold_repeat.sv -----
// Button debouncer testbench: directed and random sampled pin streams checked against an event predictor.
`timescale 1ns / 1ps
module tb_button_debounce_hold_repeat
  import bdhr_pkg::*;
;

  typedef struct packed {
    logic [BtnW-1:0]  btn;
    logic [KindW-1:0] kind;
  } btn_event_t;

  class debounce_scoreboard;
    logic [TickW-1:0] hold_ticks;
    logic [TickW-1:0] repeat_ticks;
    logic             active_level;
    logic             global_en;
    logic [7:0]       btn_mask;

    logic [2:0]       hist [8];
    logic             stab [8];
    logic [TickW-1:0] cd [8];
    logic [KindW-1:0] cur [8];
    logic [KindW-1:0] rep [8];
    logic [TickW-1:0] rcnt [8];

    btn_event_t expected_events[$];
    int         mismatch_count;

    function new();
      hold_ticks     = 10'd50;
      repeat_ticks   = 10'd10;
      active_level   = 1'b0;
      global_en      = 1'b1;
      btn_mask       = 8'hff;
      mismatch_count = 0;
      for (int b = 0; b < 8; b++) begin
        hist[b] = 3'b111;
        stab[b] = 1'b1;
        cd[b]   = '0;
        cur[b]  = KIND_RELEASED;
        rep[b]  = KIND_RELEASED;
        rcnt[b] = '0;
      end
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_HOLD_TICKS:   hold_ticks   = val;
        REG_REPEAT_TICKS: repeat_ticks = val;
        REG_ACTIVE_LEVEL: active_level = val[0];
        REG_GLOBAL_EN:    global_en    = val[0];
        REG_BUTTON_MASK:  btn_mask     = val[7:0];
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    // Predicts the event (if any) caused by one accepted sample.
    task note_sample(logic [BtnW-1:0] b, logic pin);
      logic             en;
      logic [2:0]       h;
      logic [KindW-1:0] k;
      en = global_en && btn_mask[b];
      h = {hist[b][1:0], pin};
      hist[b] = h;
      if (cd[b] != '0) begin
        cd[b] = cd[b] - 1'b1;
        if (cd[b] == '0) begin
          cur[b]  = KIND_HOLD;
          rcnt[b] = '0;
        end
      end
      if ((h == 3'b000 || h == 3'b111) && h[0] != stab[b]) begin
        stab[b] = h[0];
        if (h[0] == active_level) begin
          cd[b] = hold_ticks;
        end else begin
          cur[b] = (cd[b] != '0) ? KIND_PRESS : KIND_RELEASED;
          cd[b]  = '0;
        end
      end
      if (cur[b] != rep[b]) begin
        k = cur[b];
        if (en) begin
          if (k == KIND_PRESS) cur[b] = KIND_RELEASED;
          rep[b] = cur[b];
          expected_events.push_back('{btn: b, kind: k});
        end
      end else if (cur[b] == KIND_HOLD) begin
        rcnt[b] = rcnt[b] + 1'b1;
        if (rcnt[b] >= repeat_ticks) begin
          rcnt[b] = '0;
          rep[b]  = KIND_RELEASED;
          if (en) begin
            rep[b] = KIND_HOLD;
            expected_events.push_back('{btn: b, kind: KIND_HOLD});
          end
        end
      end
    endtask

    task check_event(logic [BtnW-1:0] b, logic [KindW-1:0] k);
      btn_event_t exp_ev;
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected event button %0d kind %0d", b, k));
      end else begin
        exp_ev = expected_events.pop_front();
        if (b !== exp_ev.btn)
          report_mismatch($sformatf("event_button %0d, expected %0d", b, exp_ev.btn));
        if (k !== exp_ev.kind)
          report_mismatch($sformatf("event_kind %0d, expected %0d (button %0d)",
                                    k, exp_ev.kind, exp_ev.btn));
      end
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;   // [2:0] button_index, [3] pin_level
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [7:0]          m_axis_tdata;   // [2:0] event_button, [4:3] event_kind
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  debounce_scoreboard sb;
  bit                 no_idle;
  bit                 no_stall;
  logic               tgt_level [8];
  int                 run_left [8];
  int                 focus_btn;

  button_debounce_hold_repeat u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) begin
    if (no_stall) begin
      m_axis_tready <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= 33);
    end
  end

  // Check first: a result never belongs to the sample accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_event(m_axis_tdata[2:0], m_axis_tdata[4:3]);
      if (s_axis_tvalid && s_axis_tready)
        sb.note_sample(s_axis_tdata[2:0], s_axis_tdata[3]);
    end
  end

  task send_sample(logic [BtnW-1:0] b, logic pin);
    while (!no_idle && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, pin, b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task wait_events_done();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task program_regs(logic [TickW-1:0] hold, logic [TickW-1:0] rpt, logic act,
                    logic gen, logic [7:0] mask);
    logic [CfgIdxW-1:0]  idx_list [5];
    logic [CfgDataW-1:0] val_list [5];
    wait_events_done();
    idx_list = '{REG_HOLD_TICKS, REG_REPEAT_TICKS, REG_ACTIVE_LEVEL, REG_GLOBAL_EN,
                 REG_BUTTON_MASK};
    val_list = '{hold, rpt, {9'd0, act}, {9'd0, gen}, {2'd0, mask}};
    cfg_we_i <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= val_list[i];
      @(posedge clk_i);
      sb.set_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Press/release runs per button with random length, some sample noise, and button hopping.
  task press_traffic(int n_items, int run_max);
    logic pin;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(99) < 25) focus_btn = $urandom_range(7);
      pin = tgt_level[focus_btn];
      if ($urandom_range(99) < 8) pin = ~pin;
      send_sample(focus_btn[2:0], pin);
      run_left[focus_btn]--;
      if (run_left[focus_btn] <= 0) begin
        tgt_level[focus_btn] = ~tgt_level[focus_btn];
        run_left[focus_btn]  = $urandom_range(run_max, 1);
      end
    end
  endtask

  initial begin
    sb = new();
    no_idle       = 1'b0;
    no_stall      = 1'b0;
    focus_btn     = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    m_axis_tready <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= REG_HOLD_TICKS;
    cfg_wdata_i   <= '0;
    for (int b = 0; b < 8; b++) begin
      tgt_level[b] = 1'b1;
      run_left[b]  = $urandom_range(8, 1);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: hold with repeat and release on button 0, short press on 7, bounce on 3.
    program_regs(10'd4, 10'd1, 1'b0, 1'b1, 8'hff);
    repeat (8) send_sample(3'd0, 1'b0);
    repeat (3) send_sample(3'd0, 1'b1);
    repeat (3) send_sample(3'd7, 1'b0);
    repeat (3) send_sample(3'd7, 1'b1);
    send_sample(3'd3, 1'b0);
    send_sample(3'd3, 1'b1);
    send_sample(3'd3, 1'b0);

    program_regs(10'd4, 10'd2, 1'b0, 1'b1, 8'hff);
    press_traffic(100, 20);
    wait_events_done();
    press_traffic(100, 20);

    program_regs(10'd10, 10'd3, 1'b1, 1'b1, 8'($urandom_range(255)));
    press_traffic(180, 40);

    no_idle  = 1'b1;
    no_stall = 1'b1;
    program_regs(10'd1, 10'd1, 1'b0, 1'b1, 8'hff);
    press_traffic(150, 10);
    no_idle  = 1'b0;
    no_stall = 1'b0;

    program_regs(10'd0, 10'd0, 1'b1, 1'b1, 8'hff);
    press_traffic(120, 10);

    program_regs(10'd1023, 10'd1023, 1'b0, 1'b1, 8'hff);
    press_traffic(80, 12);

    program_regs(10'd6, 10'd4, 1'b0, 1'b0, 8'hff);
    press_traffic(120, 30);

    program_regs(10'd5, 10'd3, 1'b0, 1'b1, 8'h00);
    press_traffic(150, 25);

    for (int p = 0; p < 2; p++) begin
      program_regs(TickW'($urandom_range(12, 1)), TickW'($urandom_range(8, 1)),
                   1'($urandom_range(1)), 1'b1, 8'($urandom_range(255)));
      press_traffic(60, 40);
    end

    wait_events_done();
    repeat (10) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
src/bdhr_pkg.sv
src/bdhr_state_ram.sv
src/bdhr_update.sv
src/bdhr_out_fifo.sv
src/button_debounce_hold_repeat.sv
tb/sv/tb_button_debounce_hold_repeat.sv
